@@ rtl/bptc_pkg.sv @@
package bptc_pkg;

    // field widths
    localparam int RAW_W    = 24;
    localparam int CAL_W    = 16;
    localparam int PRES_W   = 32;
    localparam int TENTHS_W = 16;
    localparam int IN_W     = 2 * RAW_W;
    localparam int OUT_W    = PRES_W + TENTHS_W;
    localparam int APB_DW   = 32;
    localparam int ADDR_W   = 5;
    localparam int NUM_CAL  = 6;

    // internal widths, sized from the worst-case ranges of each term
    localparam int DT_W     = RAW_W + 1;
    localparam int PROD_W   = DT_W + CAL_W + 1;
    localparam int SQP_W    = 2 * DT_W;
    localparam int TSH_W    = 19;
    localparam int TEMP_W   = TSH_W + 1;
    localparam int OFF_W    = 37;
    localparam int SENS_W   = 36;
    localparam int T2_W     = 18;
    localparam int SQ_W     = 35;
    localparam int SQ1F_W   = 2 * TSH_W;
    localparam int SQ2F_W   = 2 * TEMP_W;
    localparam int TF_W     = TEMP_W + 1;
    localparam int ABS_W    = 19;
    localparam int M61_W    = SQ_W + 6;
    localparam int M15_W    = SQ_W + 4;
    localparam int OFF2_W   = 40;
    localparam int SENS2_W  = 39;
    localparam int OFFF_W   = OFF2_W + 1;
    localparam int SENSF_W  = 40;
    localparam int LO_W     = 20;
    localparam int HI_W     = SENSF_W - LO_W;
    localparam int PLO_W    = RAW_W + LO_W;
    localparam int PHI_W    = RAW_W + 1 + HI_W;
    localparam int FULL_W   = 64;
    localparam int DIFF_W   = 48;
    localparam int QF_W     = ABS_W + 20;
    localparam int STAGES   = 9;

    // scheme constants
    localparam int TEMP_BASE  = 2000;
    localparam int KNEE_OFS   = 3500;
    localparam int C1_SH      = 16;
    localparam int C2_SH      = 17;
    localparam int C5_SH      = 8;
    localparam int SH_TEMP    = 23;
    localparam int SH_OFF     = 6;
    localparam int SH_SENS    = 7;
    localparam int SH_T2      = 31;
    localparam int SH_OFF2    = 4;
    localparam int SH_P1      = 21;
    localparam int SH_P2      = 15;
    localparam int K_OFF2     = 61;
    localparam int K_OFF3     = 15;
    localparam int SH_SENS2   = 1;
    localparam int SH_SENS3   = 3;
    localparam int DIV10_MUL  = 838861;
    localparam int DIV10_SH   = 23;

    typedef enum logic [2:0] {
        REG_C1,
        REG_C2,
        REG_C3,
        REG_C4,
        REG_C5,
        REG_C6
    } cal_reg_t;

endpackage

@@ rtl/baro_pressure_temp_compensation.sv @@
// channel   dir  handshake              payload
// s_*       in   s_tvalid / s_tready    s_tdata: raw_pressure, raw_temperature
// m_*       out  m_tvalid / m_tready    m_tdata: pressure, temperature_tenths
// apb       in   psel, penable, pwrite  paddr / pwdata / prdata, six calibration words
//
// nine register stages; a sample pair is taken every cycle while s_tready is high;
// results leave from the stage 9 out_reg. the longest stage holds one multiplier of at most
// 25 x 25 bits (the final 24 x 40 product is split into two partial products).
// each stage has its own valid bit and moves when its successor has room, so a
// downstream stall fills bubbles first and then holds s_tready low.
// rst_n clears the valid bits and the calibration words to zero.
module baro_pressure_temp_compensation (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bptc_pkg::IN_W-1:0]     s_tdata,   // raw_pressure, raw_temperature
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bptc_pkg::OUT_W-1:0]    m_tdata,   // pressure, temperature_tenths
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bptc_pkg::ADDR_W-1:0]   paddr,
    input  logic [bptc_pkg::APB_DW-1:0]   pwdata,
    output logic [bptc_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import bptc_pkg::*;

    // calibration registers
    logic [CAL_W-1:0] c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;
    logic             apb_wr;
    cal_reg_t         reg_sel;

    assign pready  = 1'b1;
    assign apb_wr  = psel & penable & pwrite;
    assign reg_sel = cal_reg_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
            c6_reg <= '0;
        end
        else if (apb_wr)
        begin
            unique case (reg_sel)
                REG_C1:  c1_reg <= pwdata[CAL_W-1:0];
                REG_C2:  c2_reg <= pwdata[CAL_W-1:0];
                REG_C3:  c3_reg <= pwdata[CAL_W-1:0];
                REG_C4:  c4_reg <= pwdata[CAL_W-1:0];
                REG_C5:  c5_reg <= pwdata[CAL_W-1:0];
                REG_C6:  c6_reg <= pwdata[CAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_C1:  prdata = APB_DW'(c1_reg);
            REG_C2:  prdata = APB_DW'(c2_reg);
            REG_C3:  prdata = APB_DW'(c3_reg);
            REG_C4:  prdata = APB_DW'(c4_reg);
            REG_C5:  prdata = APB_DW'(c5_reg);
            REG_C6:  prdata = APB_DW'(c6_reg);
            default: prdata = '0;
        endcase
    end

    // valid bits and per-stage advance
    logic [STAGES:1] vld_reg;
    logic [STAGES:1] adv;

    always_comb
    begin
        adv[STAGES] = !vld_reg[STAGES] || m_tready;
        for (int k = STAGES - 1; k >= 1; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign s_tready = adv[1];
    assign m_tvalid = vld_reg[STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[1])
            begin
                vld_reg[1] <= s_tvalid;
            end
            for (int k = 2; k <= STAGES; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // stage 1: dT
    logic [RAW_W-1:0]          d1_s1_reg;
    logic signed [DT_W-1:0]    dt_next, dt_s1_reg;

    assign dt_next = $signed({1'b0, s_tdata[IN_W-1:RAW_W]})
                   - $signed({1'b0, c5_reg, {C5_SH{1'b0}}});

    // stage 2: products of dT
    logic [RAW_W-1:0]          d1_s2_reg;
    logic signed [PROD_W-1:0]  pt_next, poff_next, psens_next;
    logic signed [PROD_W-1:0]  pt_s2_reg, poff_s2_reg, psens_s2_reg;
    logic signed [SQP_W-1:0]   sqp_next, sqp_s2_reg;

    assign pt_next    = dt_s1_reg * $signed({1'b0, c6_reg});
    assign poff_next  = dt_s1_reg * $signed({1'b0, c4_reg});
    assign psens_next = dt_s1_reg * $signed({1'b0, c3_reg});
    assign sqp_next   = dt_s1_reg * dt_s1_reg;

    // stage 3: first-order values
    logic [RAW_W-1:0]          d1_s3_reg;
    logic signed [TSH_W-1:0]   tsh_next, tsh_s3_reg;
    logic signed [TEMP_W-1:0]  temp_next, temp_s3_reg;
    logic signed [TEMP_W-1:0]  dh_next, dh_s3_reg;
    logic signed [OFF_W-1:0]   off_next, off_s3_reg;
    logic signed [SENS_W-1:0]  sens_next, sens_s3_reg;
    logic [T2_W-1:0]           t2_next, t2_s3_reg;

    assign tsh_next  = $signed(pt_s2_reg[PROD_W-1:SH_TEMP]);
    assign temp_next = TEMP_W'(tsh_next) + TEMP_W'(TEMP_BASE);
    // below -15.00 C exactly when this goes negative
    assign dh_next   = TEMP_W'(tsh_next) + TEMP_W'(KNEE_OFS);
    assign off_next  = $signed(OFF_W'({c2_reg, {C2_SH{1'b0}}}))
                     + OFF_W'($signed(poff_s2_reg[PROD_W-1:SH_OFF]));
    assign sens_next = $signed(SENS_W'({c1_reg, {C1_SH{1'b0}}}))
                     + SENS_W'($signed(psens_s2_reg[PROD_W-1:SH_SENS]));
    assign t2_next   = sqp_s2_reg[SH_T2 +: T2_W];

    // stage 4: squares of the temperature distances
    logic [RAW_W-1:0]          d1_s4_reg;
    logic signed [SQ1F_W-1:0]  sq1_full;
    logic signed [SQ2F_W-1:0]  sq2_full;
    logic [SQ_W-1:0]           sq1_s4_reg, sq2_s4_reg;
    logic signed [TF_W-1:0]    tf_next, tf_s4_reg;
    logic                      lt_ref_s4_reg, lt_low_s4_reg;
    logic signed [OFF_W-1:0]   off_s4_reg;
    logic signed [SENS_W-1:0]  sens_s4_reg;
    logic                      lt_ref_s3;

    assign lt_ref_s3 = tsh_s3_reg[TSH_W-1];
    assign sq1_full  = tsh_s3_reg * tsh_s3_reg;
    assign sq2_full  = dh_s3_reg * dh_s3_reg;
    assign tf_next   = TF_W'(temp_s3_reg)
                     - $signed(TF_W'(lt_ref_s3 ? t2_s3_reg : '0));

    // stage 5: second-order corrections, magnitude of temperature
    logic [RAW_W-1:0]          d1_s5_reg;
    logic [M61_W-1:0]          m61;
    logic [M15_W-1:0]          m15;
    logic [OFF2_W-1:0]         off2_next, off2_s5_reg;
    logic [SENS2_W-1:0]        sens2_next, sens2_s5_reg;
    logic signed [TF_W-1:0]    tf_neg;
    logic [ABS_W-1:0]          tabs_next, tabs_s5_reg;
    logic                      tsign_s5_reg;
    logic signed [OFF_W-1:0]   off_s5_reg;
    logic signed [SENS_W-1:0]  sens_s5_reg;

    assign m61    = M61_W'(sq1_s4_reg) * M61_W'(K_OFF2);
    assign m15    = M15_W'(sq2_s4_reg) * M15_W'(K_OFF3);
    assign tf_neg = -tf_s4_reg;

    always_comb
    begin
        off2_next  = '0;
        sens2_next = '0;
        if (lt_ref_s4_reg)
        begin
            off2_next  = OFF2_W'(m61 >> SH_OFF2);
            sens2_next = SENS2_W'(sq1_s4_reg) << SH_SENS2;
            if (lt_low_s4_reg)
            begin
                off2_next  = off2_next + OFF2_W'(m15);
                sens2_next = sens2_next + (SENS2_W'(sq2_s4_reg) << SH_SENS3);
            end
        end
        tabs_next = tf_s4_reg[TF_W-1] ? tf_neg[ABS_W-1:0] : tf_s4_reg[ABS_W-1:0];
    end

    // stage 6: corrected offset and sensitivity, divide by ten
    logic [RAW_W-1:0]          d1_s6_reg;
    logic signed [OFFF_W-1:0]  offf_next, offf_s6_reg;
    logic signed [SENSF_W-1:0] sensf_next, sensf_s6_reg;
    logic [QF_W-1:0]           qf;
    logic [TENTHS_W-1:0]       q_s6_reg;
    logic                      tsign_s6_reg;

    assign offf_next  = OFFF_W'(off_s5_reg) - $signed(OFFF_W'(off2_s5_reg));
    assign sensf_next = SENSF_W'(sens_s5_reg) - $signed(SENSF_W'(sens2_s5_reg));
    // reciprocal multiply, exact for magnitudes below 2^22
    assign qf         = QF_W'(tabs_s5_reg) * QF_W'(DIV10_MUL);

    // stage 7: partial products of D1 * sensitivity
    logic [PLO_W-1:0]          plo_next, plo_s7_reg;
    logic signed [PHI_W-1:0]   phi_next, phi_s7_reg;
    logic signed [OFFF_W-1:0]  offf_s7_reg;
    logic [TENTHS_W-1:0]       tenths_next, tenths_s7_reg;

    assign plo_next    = PLO_W'(d1_s6_reg) * PLO_W'(sensf_s6_reg[LO_W-1:0]);
    assign phi_next    = $signed({1'b0, d1_s6_reg}) * $signed(sensf_s6_reg[SENSF_W-1:LO_W]);
    assign tenths_next = tsign_s6_reg ? -q_s6_reg : q_s6_reg;

    // stage 8: full product
    logic signed [FULL_W-1:0]  prod_next, prod_s8_reg;
    logic signed [OFFF_W-1:0]  offf_s8_reg;
    logic [TENTHS_W-1:0]       tenths_s8_reg;

    assign prod_next = (FULL_W'(phi_s7_reg) <<< LO_W) + $signed(FULL_W'(plo_s7_reg));

    // stage 9: output register
    logic signed [DIFF_W-1:0]  diff;
    logic [OUT_W-1:0]          out_next, out_reg;

    assign diff     = DIFF_W'($signed(prod_s8_reg[FULL_W-1:SH_P1])) - DIFF_W'(offf_s8_reg);
    assign out_next = {tenths_s8_reg, diff[SH_P2 +: PRES_W]};
    assign m_tdata  = out_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            d1_s1_reg <= s_tdata[RAW_W-1:0];
            dt_s1_reg <= dt_next;
        end
        if (adv[2])
        begin
            d1_s2_reg    <= d1_s1_reg;
            pt_s2_reg    <= pt_next;
            poff_s2_reg  <= poff_next;
            psens_s2_reg <= psens_next;
            sqp_s2_reg   <= sqp_next;
        end
        if (adv[3])
        begin
            d1_s3_reg   <= d1_s2_reg;
            tsh_s3_reg  <= tsh_next;
            temp_s3_reg <= temp_next;
            dh_s3_reg   <= dh_next;
            off_s3_reg  <= off_next;
            sens_s3_reg <= sens_next;
            t2_s3_reg   <= t2_next;
        end
        if (adv[4])
        begin
            d1_s4_reg     <= d1_s3_reg;
            sq1_s4_reg    <= sq1_full[SQ_W-1:0];
            sq2_s4_reg    <= sq2_full[SQ_W-1:0];
            tf_s4_reg     <= tf_next;
            lt_ref_s4_reg <= lt_ref_s3;
            lt_low_s4_reg <= dh_s3_reg[TEMP_W-1];
            off_s4_reg    <= off_s3_reg;
            sens_s4_reg   <= sens_s3_reg;
        end
        if (adv[5])
        begin
            d1_s5_reg    <= d1_s4_reg;
            off2_s5_reg  <= off2_next;
            sens2_s5_reg <= sens2_next;
            tabs_s5_reg  <= tabs_next;
            tsign_s5_reg <= tf_s4_reg[TF_W-1];
            off_s5_reg   <= off_s4_reg;
            sens_s5_reg  <= sens_s4_reg;
        end
        if (adv[6])
        begin
            d1_s6_reg    <= d1_s5_reg;
            offf_s6_reg  <= offf_next;
            sensf_s6_reg <= sensf_next;
            q_s6_reg     <= qf[DIV10_SH +: TENTHS_W];
            tsign_s6_reg <= tsign_s5_reg;
        end
        if (adv[7])
        begin
            plo_s7_reg    <= plo_next;
            phi_s7_reg    <= phi_next;
            offf_s7_reg   <= offf_s6_reg;
            tenths_s7_reg <= tenths_next;
        end
        if (adv[8])
        begin
            prod_s8_reg   <= prod_next;
            offf_s8_reg   <= offf_s7_reg;
            tenths_s8_reg <= tenths_s7_reg;
        end
        if (adv[9])
        begin
            out_reg <= out_next;
        end
    end

endmodule
